// ===== hdl/brdtw_pkg.sv =====
`default_nettype none
package brdtw_pkg;

	localparam int MAX_LEN     = 1024;
	localparam int MAX_BAND    = 64;
	localparam int MAX_REGION  = 16;
	localparam int SAMPLE_BITS = 16;
	localparam int FRAC_BITS   = 8;

	// register widths
	localparam int SEQ_W    = 11;
	localparam int BAND_W   = 7;
	localparam int REGION_W = 5;
	localparam int RST_SEQ_LENGTH  = 1024;
	localparam int RST_BAND_HALF   = 8;
	localparam int RST_REGION_HALF = 2;

	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;

	localparam int IDX_W      = 11;
	localparam int LEN_W      = $clog2(MAX_LEN);
	localparam int BAND_SLOTS = 2 * MAX_BAND + 1;
	localparam int OFF_W      = $clog2(BAND_SLOTS);
	localparam int CROW_DEPTH = 2 * BAND_SLOTS;
	localparam int CADDR_W    = $clog2(CROW_DEPTH);
	localparam int DIR_DEPTH  = MAX_LEN * BAND_SLOTS;
	localparam int DIR_AW     = $clog2(DIR_DEPTH);
	localparam int PATH_DEPTH = 2 * MAX_LEN;
	localparam int PATH_AW    = $clog2(PATH_DEPTH);

	localparam int COST_W  = 56;
	localparam int STEPS_W = 11;
	localparam int WSUM_W  = 40;
	localparam int CW_W    = COST_W + STEPS_W;
	localparam int TERMS_W = $clog2(2 * MAX_REGION + 2);

	localparam int DIFF_W = SAMPLE_BITS + 1;
	localparam int PROD_W = 2 * DIFF_W;

	localparam int DVD_W     = WSUM_W + FRAC_BITS;
	localparam int DIV_BITS  = 8;
	localparam int DIV_STEPS = DVD_W / DIV_BITS;
	localparam int DSTEP_W   = $clog2(DIV_STEPS + 1);

	localparam int IN_DATA_W  = 48;
	localparam int OUT_DATA_W = 88;
	localparam int USER_W     = 2;

	localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};
	localparam logic [WSUM_W-1:0] WSUM_MAX = {WSUM_W{1'b1}};
	localparam logic [COST_W:0]   UNREACH  = {1'b1, {COST_W{1'b0}}};

	typedef enum logic [1:0] {
		OP_LOAD    = 2'd0,
		OP_COMPUTE = 2'd1,
		OP_READ    = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_RANGE     = 2'd1,
		ST_NOT_READY = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		MOVE_VERTICAL   = 2'd0,
		MOVE_HORIZONTAL = 2'd1,
		MOVE_DIAGONAL   = 2'd2
	} dir_t;

	typedef enum logic [1:0] {
		REG_SEQ_LENGTH        = 2'd0,
		REG_BAND_HALF_WIDTH   = 2'd1,
		REG_REGION_HALF_WIDTH = 2'd2
	} reg_idx_t;

	typedef enum logic [3:0] {
		S_IDLE, S_START, S_ROW, S_CELL, S_RDV, S_CAPV, S_SUM, S_DIV_GO,
		S_DIV, S_SEL, S_UPD, S_BT_INIT, S_BT_WR, S_BT_MV, S_FIN, S_READ
	} state_t;

	// clamped settings as used by the datapath
	typedef struct packed {
		logic [LEN_W-1:0]    len_m1;
		logic [BAND_W-1:0]   band;
		logic [REGION_W-1:0] region;
	} cfg_t;

endpackage
`default_nettype wire

// ===== hdl/brdtw_ram.sv =====
`default_nettype none
module brdtw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

// ===== hdl/brdtw_div.sv =====
`default_nettype none
module brdtw_div (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	input  wire logic [brdtw_pkg::DVD_W-1:0]     dividend,
	input  wire logic [brdtw_pkg::TERMS_W-1:0]   divisor,
	output logic                                 done,
	output logic      [brdtw_pkg::DVD_W-1:0]     quotient
);
	import brdtw_pkg::*;

	logic [DVD_W-1:0]   q_q, q_n;
	logic [TERMS_W-1:0] rem_q, rem_n;
	logic [DSTEP_W-1:0] step_q;
	logic               busy_q, done_q;

	// restoring division, DIV_BITS quotient bits per cycle
	always_comb begin
		logic [TERMS_W:0]   t;
		logic [TERMS_W-1:0] r;
		logic [DVD_W-1:0]   q;
		r = rem_q;
		q = q_q;
		for (int k = 0; k < DIV_BITS; k++) begin
			t = {r, q[DVD_W-1]};
			q = {q[DVD_W-2:0], 1'b0};
			if (t >= {1'b0, divisor}) begin
				t    = t - {1'b0, divisor};
				q[0] = 1'b1;
			end
			r = t[TERMS_W-1:0];
		end
		q_n   = q;
		rem_n = r;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= busy_q && (step_q == DSTEP_W'(1));
			if (start) begin
				busy_q <= 1'b1;
				step_q <= DSTEP_W'(DIV_STEPS);
			end else if (busy_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == DSTEP_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q   <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			q_q   <= q_n;
			rem_q <= rem_n;
		end
	end

	assign done     = done_q;
	assign quotient = q_q;
endmodule
`default_nettype wire

// ===== hdl/brdtw_cfg.sv =====
`default_nettype none
module brdtw_cfg (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [brdtw_pkg::PADDR_W-1:0] paddr,
	input  wire logic [brdtw_pkg::PDATA_W-1:0] pwdata,
	output logic      [brdtw_pkg::PDATA_W-1:0] prdata,
	output logic                               pready,
	output brdtw_pkg::cfg_t                    cfg
);
	import brdtw_pkg::*;

	logic [SEQ_W-1:0]    seq_q;
	logic [BAND_W-1:0]   band_q;
	logic [REGION_W-1:0] region_q;
	logic [1:0]          reg_idx;
	logic                wr;

	assign reg_idx = paddr[PADDR_W-1:2];
	assign wr      = psel && penable && pwrite;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q    <= SEQ_W'(RST_SEQ_LENGTH);
			band_q   <= BAND_W'(RST_BAND_HALF);
			region_q <= REGION_W'(RST_REGION_HALF);
		end else if (wr) begin
			case (reg_idx)
				REG_SEQ_LENGTH:        seq_q    <= pwdata[SEQ_W-1:0];
				REG_BAND_HALF_WIDTH:   band_q   <= pwdata[BAND_W-1:0];
				REG_REGION_HALF_WIDTH: region_q <= pwdata[REGION_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_SEQ_LENGTH:        prdata = PDATA_W'(seq_q);
			REG_BAND_HALF_WIDTH:   prdata = PDATA_W'(band_q);
			REG_REGION_HALF_WIDTH: prdata = PDATA_W'(region_q);
			default:               prdata = '0;
		endcase
	end

	// clamp to the supported ranges
	always_comb begin
		if (seq_q == '0) begin
			cfg.len_m1 = '0;
		end else if (seq_q > SEQ_W'(MAX_LEN)) begin
			cfg.len_m1 = LEN_W'(MAX_LEN - 1);
		end else begin
			cfg.len_m1 = LEN_W'(seq_q - 1'b1);
		end
		cfg.band   = (band_q > BAND_W'(MAX_BAND)) ? BAND_W'(MAX_BAND) : band_q;
		cfg.region = (region_q > REGION_W'(MAX_REGION)) ? REGION_W'(MAX_REGION) : region_q;
	end
endmodule
`default_nettype wire

// ===== hdl/banded_regional_dtw_core.sv =====
`default_nettype none
// Loads: one transaction per cycle while idle. Path read: the accepted index reads the path
// memory, S_READ loads the output register and waits while the output stalls; one transaction
// is worked on at a time. Compute: per band cell S_CELL, S_RDV, S_CAPV, serial window sum
// through the sample memory ports, the 8-bit-per-cycle divider, S_SEL and S_UPD; S_ROW per
// row; S_BT_WR and S_BT_MV per path cell. Reset (arst_n low, asynchronous) clears the control
// registers and the result flag; sample, cost-row, direction and path memories are not cleared.
module banded_regional_dtw_core (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             psel,
	input  wire logic                             penable,
	input  wire logic                             pwrite,
	input  wire logic [brdtw_pkg::PADDR_W-1:0]    paddr,
	input  wire logic [brdtw_pkg::PDATA_W-1:0]    pwdata,
	output logic      [brdtw_pkg::PDATA_W-1:0]    prdata,
	output logic                                  pready,
	input  wire logic                             s_axis_tvalid,
	output logic                                  s_axis_tready,
	// index, signal_sample, reference_sample
	input  wire logic [brdtw_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	// operation
	input  wire logic [brdtw_pkg::USER_W-1:0]     s_axis_tuser,
	output logic                                  m_axis_tvalid,
	input  wire logic                             m_axis_tready,
	// distance, path_length, path_row, path_col
	output logic      [brdtw_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	// status
	output logic      [brdtw_pkg::USER_W-1:0]     m_axis_tuser
);
	import brdtw_pkg::*;

	function automatic logic [LEN_W-1:0] min2(input logic [LEN_W-1:0] a,
		input logic [LEN_W-1:0] b);
		return (a < b) ? a : b;
	endfunction

	function automatic logic [CADDR_W-1:0] crow_addr(input logic row,
		input logic [OFF_W-1:0] off);
		return row ? CADDR_W'(BAND_SLOTS) + CADDR_W'(off) : CADDR_W'(off);
	endfunction

	cfg_t cfg;
	state_t state_q, state_n;

	brdtw_cfg u_cfg (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
	);

	logic [IDX_W-1:0]       in_index;
	logic [SAMPLE_BITS-1:0] in_sig, in_ref;
	logic                   accept;

	assign in_index = s_axis_tdata[IDX_W-1:0];
	assign in_sig   = s_axis_tdata[IDX_W+SAMPLE_BITS-1:IDX_W];
	assign in_ref   = s_axis_tdata[IDX_W+2*SAMPLE_BITS-1:IDX_W+SAMPLE_BITS];
	assign accept   = s_axis_tvalid && s_axis_tready;

	// walk registers
	logic [LEN_W-1:0]    i_q, j_q, jhi_q, sa_q, ra_q, r_q, c_q;
	logic [OFF_W-1:0]    off_q;
	logic [TERMS_W-1:0]  tleft_q, cnt_q;
	logic [CW_W-1:0]     d_q, v_q;
	logic [COST_W-1:0]   h_cost_q;
	logic [STEPS_W-1:0]  h_steps_q;
	logic [WSUM_W-1:0]   acc_q;
	logic                rd_v_s1, prod_v_s2;
	logic [PROD_W-1:0]   prod_s2;
	logic [COST_W:0]     prev_q;
	logic [STEPS_W-1:0]  plen_q;
	dir_t                dir_q;
	logic [DIR_AW-1:0]   row_base_q;
	logic [PATH_AW-1:0]  wr_addr_q;
	logic [STEPS_W-1:0]  left_q;
	logic [COST_W-1:0]   final_cost_q;
	logic [STEPS_W-1:0]  final_steps_q;
	logic                result_valid_q, rd_range_q;
	logic                out_valid_q;
	status_t             out_status_q;
	logic [COST_W-1:0]   out_dist_q;
	logic [STEPS_W-1:0]  out_len_q;
	logic [LEN_W-1:0]    out_row_q, out_col_q;

	// memories
	logic                   smem_we, smem_re;
	logic [SAMPLE_BITS-1:0] s_rdata, r_rdata;
	logic                   cmem_we, cmem_re;
	logic [CADDR_W-1:0]     cmem_waddr, cmem_raddr;
	logic [CW_W-1:0]        cmem_wdata, cmem_rdata;
	logic                   dmem_we, dmem_re;
	logic [DIR_AW-1:0]      dmem_waddr, dmem_raddr;
	logic [1:0]             dmem_rdata;
	logic                   pmem_we, pmem_re;
	logic [PATH_AW-1:0]     pmem_raddr;
	logic [2*LEN_W-1:0]     pmem_rdata;

	brdtw_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_LEN)) u_sig_mem (
		.clk, .we(smem_we), .waddr(in_index[LEN_W-1:0]), .wdata(in_sig),
		.re(smem_re), .raddr(sa_q), .rdata(s_rdata)
	);
	brdtw_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_LEN)) u_ref_mem (
		.clk, .we(smem_we), .waddr(in_index[LEN_W-1:0]), .wdata(in_ref),
		.re(smem_re), .raddr(ra_q), .rdata(r_rdata)
	);
	brdtw_ram #(.WIDTH(CW_W), .DEPTH(CROW_DEPTH)) u_cost_mem (
		.clk, .we(cmem_we), .waddr(cmem_waddr), .wdata(cmem_wdata),
		.re(cmem_re), .raddr(cmem_raddr), .rdata(cmem_rdata)
	);
	brdtw_ram #(.WIDTH(2), .DEPTH(DIR_DEPTH)) u_dir_mem (
		.clk, .we(dmem_we), .waddr(dmem_waddr), .wdata(dir_q),
		.re(dmem_re), .raddr(dmem_raddr), .rdata(dmem_rdata)
	);
	brdtw_ram #(.WIDTH(2*LEN_W), .DEPTH(PATH_DEPTH)) u_path_mem (
		.clk, .we(pmem_we), .waddr(wr_addr_q), .wdata({r_q, c_q}),
		.re(pmem_re), .raddr(pmem_raddr), .rdata(pmem_rdata)
	);

	// divider
	logic             div_start, div_done;
	logic [DVD_W-1:0] div_q;

	brdtw_div u_div (
		.clk, .arst_n, .start(div_start), .dividend({acc_q, {FRAC_BITS{1'b0}}}),
		.divisor(cnt_q), .done(div_done), .quotient(div_q)
	);

	// cell setup
	logic [LEN_W-1:0]   reg_l, band_l, lo_w, hi_w;
	logic [TERMS_W-1:0] cnt_w;
	logic [LEN_W:0]     i_plus_b;
	logic [LEN_W-1:0]   row_jlo, row_jhi;
	logic [OFF_W-1:0]   row_off, two_b, bt_off;

	assign reg_l    = LEN_W'(cfg.region);
	assign band_l   = LEN_W'(cfg.band);
	assign two_b    = OFF_W'({cfg.band, 1'b0});
	assign lo_w     = min2(min2(i_q, j_q), reg_l);
	assign hi_w     = min2(reg_l, min2(cfg.len_m1 - i_q, cfg.len_m1 - j_q));
	assign cnt_w    = TERMS_W'(lo_w) + TERMS_W'(hi_w) + TERMS_W'(1);
	assign i_plus_b = {1'b0, i_q} + (LEN_W+1)'(cfg.band);
	assign row_jlo  = (i_q > band_l) ? i_q - band_l : '0;
	assign row_off  = (i_q > band_l) ? '0 : OFF_W'(band_l - i_q);
	assign row_jhi  = (i_plus_b > {1'b0, cfg.len_m1}) ? cfg.len_m1 : i_plus_b[LEN_W-1:0];
	assign bt_off   = OFF_W'({1'b0, c_q} + (LEN_W+1)'(cfg.band) - {1'b0, r_q});

	// window term
	logic signed [DIFF_W-1:0] diff;
	logic [DIFF_W-1:0]        adiff;
	logic [WSUM_W:0]          acc_sum;

	assign diff    = $signed({s_rdata[SAMPLE_BITS-1], s_rdata})
	               - $signed({r_rdata[SAMPLE_BITS-1], r_rdata});
	assign adiff   = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
	assign acc_sum = {1'b0, acc_q} + (WSUM_W+1)'(prod_s2);

	// predecessor choice
	logic          d_ok, v_ok, h_ok, origin;
	logic [COST_W:0] dc, vc, hc;

	assign d_ok   = (i_q != '0) && (j_q != '0);
	assign v_ok   = (i_q != '0) && (off_q < two_b);
	assign h_ok   = (j_q != '0) && (off_q != '0);
	assign origin = (i_q == '0) && (j_q == '0);
	assign dc     = d_ok ? {1'b0, d_q[COST_W-1:0]} : UNREACH;
	assign vc     = v_ok ? {1'b0, v_q[COST_W-1:0]} : UNREACH;
	assign hc     = h_ok ? {1'b0, h_cost_q} : UNREACH;

	logic [COST_W+1:0]  cost_sum;
	logic [COST_W-1:0]  cost_new;
	logic [STEPS_W-1:0] steps_new;
	logic               last_cell, row_end;

	assign cost_sum  = (COST_W+2)'(div_q) + (COST_W+2)'(prev_q);
	assign cost_new  = (cost_sum > (COST_W+2)'(COST_MAX)) ? COST_MAX : cost_sum[COST_W-1:0];
	assign steps_new = plen_q + 1'b1;
	assign row_end   = (j_q == jhi_q);
	assign last_cell = row_end && (i_q == cfg.len_m1);

	dir_t bt_dir;
	logic bt_end, out_free, sum_issue, out_load;

	assign bt_dir    = dir_t'(dmem_rdata);
	assign bt_end    = ((bt_dir != MOVE_HORIZONTAL) && (r_q == '0))
	                || ((bt_dir != MOVE_VERTICAL) && (c_q == '0));
	assign out_free  = !out_valid_q || m_axis_tready;
	assign sum_issue = (state_q == S_SUM) && (tleft_q != '0);

	// next state
	always_comb begin
		state_n = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (s_axis_tuser)
						OP_COMPUTE: state_n = S_START;
						OP_READ:    state_n = S_READ;
						default:    state_n = S_IDLE;
					endcase
				end
			end
			S_START:   state_n = S_ROW;
			S_ROW:     state_n = S_CELL;
			S_CELL:    state_n = S_RDV;
			S_RDV:     state_n = S_CAPV;
			S_CAPV:    state_n = S_SUM;
			S_SUM: begin
				if (tleft_q == '0 && !rd_v_s1 && !prod_v_s2) begin
					state_n = S_DIV_GO;
				end
			end
			S_DIV_GO:  state_n = S_DIV;
			S_DIV:     state_n = div_done ? S_SEL : S_DIV;
			S_SEL:     state_n = S_UPD;
			S_UPD:     state_n = last_cell ? S_BT_INIT : (row_end ? S_ROW : S_CELL);
			S_BT_INIT: state_n = S_BT_WR;
			S_BT_WR:   state_n = (left_q == '0) ? S_FIN : S_BT_MV;
			S_BT_MV:   state_n = bt_end ? S_FIN : S_BT_WR;
			S_FIN:     state_n = out_free ? S_IDLE : S_FIN;
			S_READ:    state_n = out_free ? S_IDLE : S_READ;
			default:   state_n = S_IDLE;
		endcase
	end

	// memory and handshake controls
	always_comb begin
		s_axis_tready = (state_q == S_IDLE);
		smem_we    = accept && (s_axis_tuser == OP_LOAD) && (in_index < IDX_W'(MAX_LEN));
		smem_re    = sum_issue;
		cmem_re    = 1'b0;
		cmem_raddr = crow_addr(!i_q[0], off_q);
		cmem_we    = (state_q == S_UPD);
		cmem_waddr = crow_addr(i_q[0], off_q);
		cmem_wdata = {steps_new, cost_new};
		dmem_we    = (state_q == S_UPD);
		dmem_waddr = row_base_q + DIR_AW'(off_q);
		dmem_re    = (state_q == S_BT_WR);
		dmem_raddr = row_base_q + DIR_AW'(bt_off);
		pmem_we    = (state_q == S_BT_WR) && (left_q != '0);
		pmem_re    = accept && (s_axis_tuser == OP_READ);
		pmem_raddr = PATH_AW'(in_index);
		div_start  = (state_q == S_DIV_GO);
		out_load   = ((state_q == S_FIN) || (state_q == S_READ)) && out_free;
		case (state_q)
			S_CELL: cmem_re = 1'b1;
			S_RDV: begin
				// fetch the upper neighbor only where it lies inside the band
				cmem_re    = (off_q < two_b);
				cmem_raddr = crow_addr(!i_q[0], off_q + 1'b1);
			end
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			result_valid_q <= 1'b0;
			out_valid_q    <= 1'b0;
			rd_v_s1        <= 1'b0;
			prod_v_s2      <= 1'b0;
			final_cost_q   <= '0;
			final_steps_q  <= '0;
		end else begin
			state_q   <= state_n;
			rd_v_s1   <= sum_issue;
			prod_v_s2 <= rd_v_s1;
			if (state_q == S_UPD && last_cell) begin
				final_cost_q  <= cost_new;
				final_steps_q <= steps_new;
			end
			if (state_q == S_FIN && out_free) begin
				result_valid_q <= 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (rd_v_s1) begin
			prod_s2 <= adiff * adiff;
		end
		if (prod_v_s2) begin
			acc_q <= acc_sum[WSUM_W] ? WSUM_MAX : acc_sum[WSUM_W-1:0];
		end
		if (sum_issue) begin
			sa_q    <= sa_q + 1'b1;
			ra_q    <= ra_q + 1'b1;
			tleft_q <= tleft_q - 1'b1;
		end
		if (accept && s_axis_tuser == OP_READ) begin
			rd_range_q <= (in_index >= final_steps_q);
		end
		case (state_q)
			S_START: begin
				i_q        <= '0;
				row_base_q <= '0;
			end
			S_ROW: begin
				j_q   <= row_jlo;
				off_q <= row_off;
				jhi_q <= row_jhi;
			end
			S_CELL: begin
				sa_q    <= i_q - lo_w;
				ra_q    <= j_q - lo_w;
				tleft_q <= cnt_w;
				cnt_q   <= cnt_w;
				acc_q   <= '0;
			end
			S_RDV:  d_q <= cmem_rdata;
			S_CAPV: v_q <= cmem_rdata;
			S_SEL: begin
				// ties: diagonal, then vertical, then horizontal
				if (origin) begin
					prev_q <= '0;
					plen_q <= '0;
					dir_q  <= MOVE_DIAGONAL;
				end else if (dc <= vc && dc <= hc) begin
					prev_q <= dc;
					plen_q <= d_q[CW_W-1:COST_W];
					dir_q  <= MOVE_DIAGONAL;
				end else if (vc < dc && vc <= hc) begin
					prev_q <= vc;
					plen_q <= v_q[CW_W-1:COST_W];
					dir_q  <= MOVE_VERTICAL;
				end else begin
					prev_q <= hc;
					plen_q <= h_steps_q;
					dir_q  <= MOVE_HORIZONTAL;
				end
			end
			S_UPD: begin
				h_cost_q  <= cost_new;
				h_steps_q <= steps_new;
				if (row_end && !last_cell) begin
					i_q        <= i_q + 1'b1;
					row_base_q <= row_base_q + DIR_AW'(BAND_SLOTS);
				end else if (!row_end) begin
					j_q   <= j_q + 1'b1;
					off_q <= off_q + 1'b1;
				end
			end
			S_BT_INIT: begin
				r_q       <= cfg.len_m1;
				c_q       <= cfg.len_m1;
				wr_addr_q <= PATH_AW'(final_steps_q - 1'b1);
				left_q    <= final_steps_q;
			end
			S_BT_MV: begin
				wr_addr_q <= wr_addr_q - 1'b1;
				left_q    <= left_q - 1'b1;
				if (bt_dir != MOVE_HORIZONTAL) begin
					r_q        <= r_q - 1'b1;
					row_base_q <= row_base_q - DIR_AW'(BAND_SLOTS);
				end
				if (bt_dir != MOVE_VERTICAL) begin
					c_q <= c_q - 1'b1;
				end
			end
			default: ;
		endcase
		if (out_load) begin
			out_status_q <= ST_OK;
			out_dist_q   <= final_cost_q;
			out_len_q    <= final_steps_q;
			out_row_q    <= '0;
			out_col_q    <= '0;
			if (!result_valid_q && state_q == S_READ) begin
				out_status_q <= ST_NOT_READY;
				out_dist_q   <= '0;
				out_len_q    <= '0;
			end else if (state_q == S_READ) begin
				if (rd_range_q) begin
					out_status_q <= ST_RANGE;
				end else begin
					out_row_q <= pmem_rdata[2*LEN_W-1:LEN_W];
					out_col_q <= pmem_rdata[LEN_W-1:0];
				end
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_status_q;
	assign m_axis_tdata  = {{(OUT_DATA_W-COST_W-STEPS_W-2*LEN_W){1'b0}},
	                        out_col_q, out_row_q, out_len_q, out_dist_q};

	a_cost_rw_apart: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmem_we && cmem_re && (cmem_waddr == cmem_raddr)))
		else $error("cost row read and write collide");

	a_div_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == S_DIV))
		else $error("divider finished outside its wait state");

	a_path_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_BT_WR || state_q == S_BT_MV) |-> (left_q <= final_steps_q))
		else $error("backtrack count exceeds path length");

	a_result_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN && out_free) |=> (result_valid_q && out_valid_q))
		else $error("compute result not marked valid");

endmodule
`default_nettype wire

// ===== sim/tb_banded_regional_dtw_core.sv =====
`default_nettype none
module tb_banded_regional_dtw_core;
	timeunit 1ns;
	timeprecision 1ps;

	import brdtw_pkg::*;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam longint unsigned COST_SAT  = (64'd1 << 56) - 64'd1;
	localparam longint unsigned NO_PATH   = 64'd1 << 56;
	localparam longint unsigned WSUM_SAT  = (64'd1 << 40) - 64'd1;

	typedef struct {
		status_t     status;
		logic [55:0] distance;
		logic [10:0] path_length;
		logic [9:0]  path_row;
		logic [9:0]  path_col;
	} warp_result_t;

	class warp_scoreboard;
		int sig_mem[MAX_LEN];
		int ref_mem[MAX_LEN];
		longint unsigned cost_row[2][BAND_SLOTS];
		int steps_row[2][BAND_SLOTS];
		logic [1:0] dir_mem[MAX_LEN][BAND_SLOTS];
		int path_r[PATH_DEPTH];
		int path_c[PATH_DEPTH];
		longint unsigned total_cost;
		int total_steps;
		bit have_path;
		int seq_reg, band_reg, region_reg;
		warp_result_t pending_q[$];
		int errors;

		function new();
			seq_reg = 1024;
			band_reg = 8;
			region_reg = 2;
			have_path = 0;
			total_cost = 0;
			total_steps = 0;
			errors = 0;
		endfunction

		function void set_reg(reg_idx_t idx, int value);
			case (idx)
				REG_SEQ_LENGTH: seq_reg = value & 'h7ff;
				REG_BAND_HALF_WIDTH: band_reg = value & 'h7f;
				REG_REGION_HALF_WIDTH: region_reg = value & 'h1f;
				default: ;
			endcase
		endfunction

		function int eff_len();
			return seq_reg < 1 ? 1 : (seq_reg > MAX_LEN ? MAX_LEN : seq_reg);
		endfunction

		function longint unsigned window_mean(longint unsigned sum, longint unsigned cnt);
			longint unsigned q, rm, v;
			q = sum / cnt;
			rm = sum % cnt;
			if (q > (COST_SAT >> FRAC_BITS)) return COST_SAT;
			v = (q << FRAC_BITS) + ((rm << FRAC_BITS) / cnt);
			return v > COST_SAT ? COST_SAT : v;
		endfunction

		function void fill_band();
			int L, B, R, lo, hi, off, cur, prv, jlo, jhi, r, c, n;
			longint unsigned sum, lc, prev, d, v, h, df;
			int plen;
			logic [1:0] dir;
			L = eff_len();
			B = band_reg > MAX_BAND ? MAX_BAND : band_reg;
			R = region_reg > MAX_REGION ? MAX_REGION : region_reg;
			for (int i = 0; i < L; i++) begin
				cur = i & 1;
				prv = cur ^ 1;
				jlo = i - B < 0 ? 0 : i - B;
				jhi = (i + B < L - 1) ? i + B : L - 1;
				for (int j = jlo; j <= jhi; j++) begin
					off = j - i + B;
					lo = i < j ? i : j;
					lo = lo < R ? lo : R;
					hi = (L - 1 - i < L - 1 - j) ? L - 1 - i : L - 1 - j;
					hi = hi < R ? hi : R;
					sum = 0;
					for (int m = -lo; m <= hi; m++) begin
						df = sig_mem[i+m] > ref_mem[j+m] ? sig_mem[i+m] - ref_mem[j+m]
							: ref_mem[j+m] - sig_mem[i+m];
						sum += df * df;
						if (sum > WSUM_SAT) sum = WSUM_SAT;
					end
					lc = window_mean(sum, lo + hi + 1);
					prev = 0;
					plen = 0;
					dir = MOVE_DIAGONAL;
					if (i != 0 || j != 0) begin
						d = (i > 0 && j > 0) ? cost_row[prv][off] : NO_PATH;
						v = (i > 0 && off + 1 <= 2 * B) ? cost_row[prv][off+1] : NO_PATH;
						h = (j > 0 && off > 0) ? cost_row[cur][off-1] : NO_PATH;
						if (d <= v && d <= h) begin
							dir = MOVE_DIAGONAL;
							prev = d;
							plen = d != NO_PATH ? steps_row[prv][off] : 0;
						end else if (v < d && v <= h) begin
							dir = MOVE_VERTICAL;
							prev = v;
							plen = v != NO_PATH ? steps_row[prv][off+1] : 0;
						end else begin
							dir = MOVE_HORIZONTAL;
							prev = h;
							plen = h != NO_PATH ? steps_row[cur][off-1] : 0;
						end
					end
					lc += prev;
					cost_row[cur][off] = lc > COST_SAT ? COST_SAT : lc;
					steps_row[cur][off] = (plen + 1) & 'hffff;
					dir_mem[i][off] = dir;
				end
			end
			total_cost = cost_row[(L-1)&1][B];
			total_steps = steps_row[(L-1)&1][B];
			n = total_steps > PATH_DEPTH ? PATH_DEPTH : total_steps;
			r = L - 1;
			c = L - 1;
			for (int k = 0; k < n; k++) begin
				off = c - r + B;
				path_r[n-1-k] = r;
				path_c[n-1-k] = c;
				if (off < 0 || off > 2 * B) break;
				dir = dir_mem[r][off];
				if (dir == MOVE_VERTICAL) r--;
				else if (dir == MOVE_HORIZONTAL) c--;
				else begin
					r--;
					c--;
				end
				if (r < 0 || c < 0) break;
			end
			have_path = 1;
		endfunction

		// note an accepted input transaction and queue what it should produce
		function void note(logic [1:0] op, int idx, logic [15:0] s, logic [15:0] rs);
			warp_result_t e;
			// only the low eleven bits travel on the bus
			idx = idx & 'h7ff;
			if (op == OP_LOAD) begin
				if (idx < MAX_LEN) begin
					sig_mem[idx] = $signed(s);
					ref_mem[idx] = $signed(rs);
				end
				return;
			end
			if (op == OP_UNUSED) return;
			if (op == OP_COMPUTE) fill_band();
			e.status = ST_OK;
			e.distance = 0;
			e.path_length = 0;
			e.path_row = 0;
			e.path_col = 0;
			if (!have_path) begin
				e.status = ST_NOT_READY;
			end else begin
				e.distance = total_cost[55:0];
				e.path_length = total_steps[10:0];
				if (op == OP_READ) begin
					if (idx >= total_steps || idx >= PATH_DEPTH) e.status = ST_RANGE;
					else begin
						e.path_row = path_r[idx][9:0];
						e.path_col = path_c[idx][9:0];
					end
				end
			end
			pending_q.push_back(e);
		endfunction

		function void check(logic [1:0] st, logic [OUT_DATA_W-1:0] dat);
			warp_result_t e;
			if (pending_q.size() == 0) begin
				$display("%0t: unexpected result status=%0d data=%h", $time, st, dat);
				errors++;
				return;
			end
			e = pending_q.pop_front();
			if (st !== e.status) begin
				$display("%0t: status exp %0d got %0d", $time, e.status, st);
				errors++;
			end
			if (dat[55:0] !== e.distance) begin
				$display("%0t: distance exp %0d got %0d", $time, e.distance, dat[55:0]);
				errors++;
			end
			if (dat[66:56] !== e.path_length) begin
				$display("%0t: path_length exp %0d got %0d", $time, e.path_length, dat[66:56]);
				errors++;
			end
			if (dat[76:67] !== e.path_row) begin
				$display("%0t: path_row exp %0d got %0d", $time, e.path_row, dat[76:67]);
				errors++;
			end
			if (dat[86:77] !== e.path_col) begin
				$display("%0t: path_col exp %0d got %0d", $time, e.path_col, dat[86:77]);
				errors++;
			end
		endfunction
	endclass

	logic clk, arst_n;
	logic psel, penable, pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata, prdata;
	logic pready;
	logic s_axis_tvalid, s_axis_tready;
	logic [IN_DATA_W-1:0] s_axis_tdata;  // index, signal_sample, reference_sample
	logic [USER_W-1:0] s_axis_tuser;     // operation
	logic m_axis_tvalid, m_axis_tready;
	logic [OUT_DATA_W-1:0] m_axis_tdata; // distance, path_length, path_row, path_col
	logic [USER_W-1:0] m_axis_tuser;     // status

	banded_regional_dtw_core uut (.*);

	warp_scoreboard warp_sb;
	int send_idle_pct, recv_stall_pct, sent_count;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("CHECKS FAILED");
		$finish;
	end

	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
		if (arst_n && m_axis_tvalid && m_axis_tready) warp_sb.check(m_axis_tuser, m_axis_tdata);
	end

	task automatic send(logic [1:0] op, int idx, logic [15:0] s, logic [15:0] rs);
		if ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= op;
		s_axis_tdata <= {5'd0, rs, s, idx[10:0]};
		do @(posedge clk); while (!s_axis_tready);
		warp_sb.note(op, idx, s, rs);
		sent_count++;
	endtask

	// hold the input side until every queued result is back
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (warp_sb.pending_q.size() != 0) @(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic reg_write(reg_idx_t idx, int value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= PADDR_W'(4 * idx);
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		warp_sb.set_reg(idx, value);
	endtask

	task automatic configure(int len, int band, int region);
		drain();
		reg_write(REG_SEQ_LENGTH, len);
		reg_write(REG_BAND_HALF_WIDTH, band);
		reg_write(REG_REGION_HALF_WIDTH, region);
	endtask

	function automatic logic [15:0] rand_sample();
		case ($urandom_range(9))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'($urandom_range(7));
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic noise();
		case ($urandom_range(2))
			0: send(OP_UNUSED, $urandom_range(2047), 16'($urandom), 16'($urandom));
			1: send(OP_LOAD, $urandom_range(MAX_LEN, 2047), 16'($urandom), 16'($urandom));
			default: send(OP_READ, $urandom_range(2047), 16'($urandom), 16'($urandom));
		endcase
	endtask

	// one warp: settings, full load of both sequences, compute, then path reads
	task automatic warp_run(int len, int band, int region, int reads);
		int L, lim;
		configure(len, band, region);
		L = warp_sb.eff_len();
		for (int i = 0; i < L; i++) begin
			if ($urandom_range(19) == 0) noise();
			send(OP_LOAD, i, rand_sample(), rand_sample());
		end
		send(OP_COMPUTE, $urandom_range(2047), 16'($urandom), 16'($urandom));
		lim = 2 * L + 2;
		for (int k = 0; k < reads; k++) begin
			if ($urandom_range(19) == 0) noise();
			else if ($urandom_range(15) == 0)
				send(OP_READ, 2047, 16'($urandom), 16'($urandom));
			else send(OP_READ, $urandom_range(lim), 16'($urandom), 16'($urandom));
		end
	endtask

	task automatic random_run();
		int len, band, region;
		len = $urandom_range(4) == 0 ? $urandom_range(21, 48) : $urandom_range(1, 20);
		band = $urandom_range(5) == 0 ? ($urandom_range(1) ? 127 : 64) : $urandom_range(6);
		region = $urandom_range(5) == 0 ? ($urandom_range(1) ? 31 : 16) : $urandom_range(4);
		if (len > 20) begin
			band = $urandom_range(6);
			region = $urandom_range(4);
		end
		warp_run(len, band, region, $urandom_range(len, 2 * len + 8));
	endtask

	initial begin
		int limits[4];
		int idle_set[4];
		int stall_set[4];
		limits = '{1250, 1450, 1650, 1850};
		idle_set = '{0, 69, 0, 38};
		stall_set = '{0, 0, 69, 38};
		warp_sb = new();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		sent_count = 0;
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		s_axis_tuser <= OP_LOAD;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// read before any compute, ignored codes, loads past the store
		send(OP_READ, 0, 0, 0);
		send(OP_UNUSED, 5, 16'hffff, 16'hffff);
		send(OP_LOAD, MAX_LEN, 16'h1234, 16'h4321);
		send(OP_LOAD, 2047, 16'hffff, 16'hffff);
		send(OP_READ, 2047, 0, 0);
		// single-sample sequence from a zero length setting
		configure(0, 0, 0);
		send(OP_LOAD, 0, 16'h8000, 16'h7fff);
		send(OP_COMPUTE, 0, 0, 0);
		send(OP_READ, 0, 0, 0);
		send(OP_READ, 1, 0, 0);
		// zero band, widest window, extreme samples
		configure(8, 0, 31);
		for (int i = 0; i < 8; i++)
			send(OP_LOAD, i, i[0] ? 16'h7fff : 16'h8000, i[1] ? 16'h8000 : 16'h7fff);
		send(OP_COMPUTE, 0, 0, 0);
		send(OP_READ, 0, 0, 0);
		send(OP_READ, 7, 0, 0);
		send(OP_READ, 8, 0, 0);
		send(OP_UNUSED, 0, 0, 0);
		send(OP_LOAD, 3, 16'h0000, 16'h0000);
		send(OP_READ, 3, 0, 0);
		// full length sequence through the narrowest band
		warp_run(2047, 0, 0, 12);
		warp_run(40, 127, 31, 20);

		for (int p = 0; p < 4; p++) begin
			drain();
			send_idle_pct = idle_set[p];
			recv_stall_pct = stall_set[p];
			while (sent_count < limits[p]) random_run();
		end

		drain();
		repeat (20) @(posedge clk);
		if (warp_sb.errors == 0 && warp_sb.pending_q.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end
endmodule
`default_nettype wire
